@@ hw/rtl/wifi_station_traffic_table_macros.svh @@
// ----------------------------------------------------------------------------
// Station traffic table assertion macros
// Shared concurrent assertion forms, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef WIFI_STATION_TRAFFIC_TABLE_MACROS_SVH
`define WIFI_STATION_TRAFFIC_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WSTT_ASSERT_HOLDS(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("station traffic table check failed");
`define WSTT_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("station traffic table sequence check failed");
`else
`define WSTT_ASSERT_HOLDS(lbl, clk, rst_n, cond, prop)
`define WSTT_ASSERT_NEXT(lbl, clk, rst_n, cond, prop)
`endif
`endif

@@ hw/rtl/wstt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Station traffic table package
// Beat types, status codes and command codes shared by the block.
// ----------------------------------------------------------------------------
package wstt_pkg;

    typedef logic [47:0] mac_t;

    localparam mac_t BROADCAST_MAC = 48'hffff_ffff_ffff;

    typedef enum logic [2:0] {
        ST_COUNTED = 3'd0,
        ST_MISSING = 3'd1,
        ST_FULL    = 3'd2,
        ST_FOUND   = 3'd3,
        ST_NONE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_FRAME   = 2'd0,
        OP_PARTIAL = 2'd1,
        OP_QUERY   = 2'd2
    } op_t;

    typedef struct packed {
        logic kind;
        logic is_beacon;
        logic has_transmitter;
        logic has_receiver;
        mac_t transmitter;
        mac_t receiver;
        mac_t station;
    } item_t;

    typedef struct packed {
        status_t status;
        mac_t    partner;
    } result_t;

    typedef struct packed {
        op_t  op;
        logic beacon;
        mac_t key_a;
        mac_t key_b;
    } cmd_t;

endpackage

@@ hw/rtl/wstt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Station traffic table front end
// Accepts beats, classifies them into commands and queues them for the back end.
// ----------------------------------------------------------------------------
module wstt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  wstt_pkg::item_t item,
    output logic            cmd_valid,
    output wstt_pkg::cmd_t  cmd,
    input  logic            cmd_pop
);
    import wstt_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cmd_t       cls;

    always_comb
    begin
        cls.beacon = item.is_beacon & item.has_transmitter;
        if (item.kind)
        begin
            cls.op    = OP_QUERY;
            cls.key_a = item.station;
        end
        else
        begin
            cls.op    = (item.has_transmitter & item.has_receiver) ? OP_FRAME : OP_PARTIAL;
            cls.key_a = item.transmitter;
        end
        cls.key_b = item.receiver;
    end

    assign item_stall = (cnt_reg == 2'd2);
    assign push       = item_valid & ~item_stall;
    assign cmd_valid  = (cnt_reg != 2'd0);
    assign cmd        = q_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = cmd_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg;
        if (push && !cmd_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cls;
        end
    end

endmodule

@@ hw/rtl/wstt_back.sv @@
`timescale 1ns / 1ps
`include "wifi_station_traffic_table_macros.svh"
// ----------------------------------------------------------------------------
// Station traffic table back end
// Sequencer over the access point, client and pair memories; one command at a time.
// ----------------------------------------------------------------------------
module wstt_back #(
    parameter int AP_ENTRIES     = 16,
    parameter int CLIENT_ENTRIES = 64,
    parameter int PAIR_ENTRIES   = 256,
    parameter int COUNT_BITS     = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  wstt_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output logic              result_valid,
    input  logic              result_stall,
    output wstt_pkg::result_t result
);
    import wstt_pkg::*;

    localparam int AW   = (AP_ENTRIES > 1) ? $clog2(AP_ENTRIES) : 1;
    localparam int CW   = (CLIENT_ENTRIES > 1) ? $clog2(CLIENT_ENTRIES) : 1;
    localparam int PW   = (PAIR_ENTRIES > 1) ? $clog2(PAIR_ENTRIES) : 1;
    localparam int ACW  = $clog2(AP_ENTRIES + 1);
    localparam int CCW  = $clog2(CLIENT_ENTRIES + 1);
    localparam int PCW  = $clog2(PAIR_ENTRIES + 1);
    localparam int MAXE = (PAIR_ENTRIES > CLIENT_ENTRIES) ?
                          ((PAIR_ENTRIES > AP_ENTRIES) ? PAIR_ENTRIES : AP_ENTRIES) :
                          ((CLIENT_ENTRIES > AP_ENTRIES) ? CLIENT_ENTRIES : AP_ENTRIES);
    localparam int SW   = $clog2(MAXE + 1);

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        mac_t            addr;
        logic            best_valid;
        logic [CW-1:0]   best_client;
        count_t          best_count;
    } ap_ent_t;

    typedef struct packed {
        logic [AW-1:0] ap;
        mac_t          addr;
        count_t        rx;
        count_t        tx;
    } cl_ent_t;

    typedef struct packed {
        mac_t   src;
        mac_t   dst;
        count_t cnt;
    } pr_ent_t;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_APSCAN = 12'b0000_0000_0010,
        S_APINS  = 12'b0000_0000_0100,
        S_CLSCAN = 12'b0000_0000_1000,
        S_CLUPD  = 12'b0000_0001_0000,
        S_BEST   = 12'b0000_0010_0000,
        S_PRSCAN = 12'b0000_0100_0000,
        S_PRUPD  = 12'b0000_1000_0000,
        S_QBEST  = 12'b0001_0000_0000,
        S_QCL    = 12'b0010_0000_0000,
        S_QSCAN  = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    localparam count_t COUNT_MAX = '1;

    ap_ent_t ap_mem [AP_ENTRIES];
    cl_ent_t cl_mem [CLIENT_ENTRIES];
    pr_ent_t pr_mem [PAIR_ENTRIES];

    logic          ap_we, cl_we, pr_we;
    logic [AW-1:0] ap_waddr, ap_raddr;
    logic [CW-1:0] cl_waddr, cl_raddr;
    logic [PW-1:0] pr_waddr, pr_raddr;
    ap_ent_t       ap_wdata, ap_rd;
    cl_ent_t       cl_wdata, cl_rd;
    pr_ent_t       pr_wdata, pr_rd;

    state_t         state_reg, state_next;
    logic [ACW-1:0] ap_cnt_reg, ap_cnt_next;
    logic [CCW-1:0] cl_cnt_reg, cl_cnt_next;
    logic [PCW-1:0] pr_cnt_reg, pr_cnt_next;
    logic           out_valid_reg, out_valid_next;
    logic           pv_reg, pv_next;
    logic           qv_reg, qv_next;

    cmd_t          cmd_reg, cmd_next;
    logic [SW-1:0] si_reg, si_next;
    logic [SW-1:0] pidx_reg, pidx_next;
    logic [SW-1:0] fidx_reg, fidx_next;
    logic          txh_reg, txh_next, rxh_reg, rxh_next;
    logic [AW-1:0] txi_reg, txi_next, rxi_reg, rxi_next;
    logic          dropped_reg, dropped_next;
    logic          ph_reg, ph_next;
    logic [AW-1:0] cl_ap_reg, cl_ap_next;
    mac_t          cl_addr_reg, cl_addr_next;
    logic          rxmode_reg, rxmode_next;
    logic          fnew_reg, fnew_next;
    count_t        crx_reg, crx_next, ctx_reg, ctx_next;
    count_t        qrx_reg, qrx_next, brx_reg, brx_next;
    logic          have_reg, have_next;
    mac_t          bap_reg, bap_next;
    status_t       status_reg, status_next;
    mac_t          partner_reg, partner_next;
    result_t       out_reg, out_next;

    logic [SW-1:0] lim;
    logic          scan_issue;
    logic          t_h, r_h, drop;
    logic [AW-1:0] t_i, r_i;

    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign cmd_pop      = cmd_valid && (state_reg == S_IDLE);

    always_comb
    begin
        case (state_reg)
            S_APSCAN:          lim = SW'(ap_cnt_reg);
            S_CLSCAN, S_QSCAN: lim = SW'(cl_cnt_reg);
            S_PRSCAN:          lim = SW'(pr_cnt_reg);
            default:           lim = '0;
        endcase
    end

    assign scan_issue = (si_reg < lim);

    always_comb
    begin
        state_next     = state_reg;
        ap_cnt_next    = ap_cnt_reg;
        cl_cnt_next    = cl_cnt_reg;
        pr_cnt_next    = pr_cnt_reg;
        out_valid_next = out_valid_reg & result_stall;
        out_next       = out_reg;
        pv_next        = 1'b0;
        qv_next        = 1'b0;
        cmd_next       = cmd_reg;
        si_next        = si_reg;
        pidx_next      = si_reg;
        fidx_next      = fidx_reg;
        txh_next       = txh_reg;
        rxh_next       = rxh_reg;
        txi_next       = txi_reg;
        rxi_next       = rxi_reg;
        dropped_next   = dropped_reg;
        ph_next        = ph_reg;
        cl_ap_next     = cl_ap_reg;
        cl_addr_next   = cl_addr_reg;
        rxmode_next    = rxmode_reg;
        fnew_next      = fnew_reg;
        crx_next       = crx_reg;
        ctx_next       = ctx_reg;
        qrx_next       = qrx_reg;
        brx_next       = brx_reg;
        have_next      = have_reg;
        bap_next       = bap_reg;
        status_next    = status_reg;
        partner_next   = partner_reg;
        ap_we          = 1'b0;
        cl_we          = 1'b0;
        pr_we          = 1'b0;
        ap_waddr       = '0;
        cl_waddr       = '0;
        pr_waddr       = '0;
        ap_wdata       = '0;
        cl_wdata       = '0;
        pr_wdata       = '0;
        ap_raddr       = si_reg[AW-1:0];
        cl_raddr       = si_reg[CW-1:0];
        pr_raddr       = si_reg[PW-1:0];
        t_h            = txh_reg;
        r_h            = rxh_reg;
        t_i            = txi_reg;
        r_i            = rxi_reg;
        drop           = 1'b0;

        if (state_reg == S_APSCAN || state_reg == S_CLSCAN ||
            state_reg == S_PRSCAN || state_reg == S_QSCAN)
        begin
            pv_next = scan_issue;
            if (scan_issue)
            begin
                si_next = si_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next     = cmd;
                    si_next      = '0;
                    txh_next     = 1'b0;
                    rxh_next     = 1'b0;
                    dropped_next = 1'b0;
                    have_next    = 1'b0;
                    partner_next = '0;
                    state_next   = S_APSCAN;
                end
            end
            S_APSCAN:
            begin
                if (pv_reg)
                begin
                    if (!txh_reg && ap_rd.addr == cmd_reg.key_a)
                    begin
                        txh_next = 1'b1;
                        txi_next = pidx_reg[AW-1:0];
                    end
                    if (!rxh_reg && ap_rd.addr == cmd_reg.key_b)
                    begin
                        rxh_next = 1'b1;
                        rxi_next = pidx_reg[AW-1:0];
                    end
                end
                else if (!scan_issue)
                begin
                    si_next = '0;
                    ph_next = 1'b0;
                    if (cmd_reg.op == OP_QUERY)
                    begin
                        state_next = txh_reg ? S_QBEST : S_QSCAN;
                    end
                    else
                    begin
                        state_next = S_APINS;
                    end
                end
            end
            S_APINS:
            begin
                if (cmd_reg.beacon && !txh_reg)
                begin
                    if (ap_cnt_reg < ACW'(AP_ENTRIES))
                    begin
                        ap_we                = 1'b1;
                        ap_waddr             = ap_cnt_reg[AW-1:0];
                        ap_wdata.addr        = cmd_reg.key_a;
                        ap_wdata.best_valid  = 1'b0;
                        t_h                  = 1'b1;
                        t_i                  = ap_cnt_reg[AW-1:0];
                        if (cmd_reg.key_b == cmd_reg.key_a)
                        begin
                            r_h = 1'b1;
                            r_i = ap_cnt_reg[AW-1:0];
                        end
                        ap_cnt_next = ap_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        drop = 1'b1;
                    end
                end
                dropped_next = drop;
                txh_next     = t_h;
                txi_next     = t_i;
                rxh_next     = r_h;
                rxi_next     = r_i;
                si_next      = '0;
                if (cmd_reg.op != OP_FRAME)
                begin
                    status_next = drop ? ST_FULL : ST_MISSING;
                    state_next  = S_DONE;
                end
                else if (t_h && cmd_reg.key_b != BROADCAST_MAC)
                begin
                    cl_ap_next   = t_i;
                    cl_addr_next = cmd_reg.key_b;
                    rxmode_next  = 1'b1;
                    state_next   = S_CLSCAN;
                end
                else if (r_h && cmd_reg.key_a != BROADCAST_MAC)
                begin
                    cl_ap_next   = r_i;
                    cl_addr_next = cmd_reg.key_a;
                    rxmode_next  = 1'b0;
                    state_next   = S_CLSCAN;
                end
                else
                begin
                    state_next = S_PRSCAN;
                end
            end
            S_CLSCAN:
            begin
                if (pv_reg && cl_rd.ap == cl_ap_reg && cl_rd.addr == cl_addr_reg)
                begin
                    fidx_next  = pidx_reg;
                    fnew_next  = 1'b0;
                    crx_next   = cl_rd.rx;
                    ctx_next   = cl_rd.tx;
                    state_next = S_CLUPD;
                end
                else if (!pv_reg && !scan_issue)
                begin
                    if (cl_cnt_reg < CCW'(CLIENT_ENTRIES))
                    begin
                        fidx_next  = SW'(cl_cnt_reg);
                        fnew_next  = 1'b1;
                        crx_next   = '0;
                        ctx_next   = '0;
                        state_next = S_CLUPD;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                end
            end
            S_CLUPD:
            begin
                cl_we         = 1'b1;
                cl_waddr      = fidx_reg[CW-1:0];
                cl_wdata.ap   = cl_ap_reg;
                cl_wdata.addr = cl_addr_reg;
                cl_wdata.rx   = rxmode_reg ? sat_inc(crx_reg) : crx_reg;
                cl_wdata.tx   = rxmode_reg ? ctx_reg : sat_inc(ctx_reg);
                if (fnew_reg)
                begin
                    cl_cnt_next = cl_cnt_reg + 1'b1;
                end
                if (rxmode_reg)
                begin
                    status_next = dropped_reg ? ST_FULL : ST_COUNTED;
                    state_next  = S_DONE;
                end
                else
                begin
                    ctx_next   = sat_inc(ctx_reg);
                    ph_next    = 1'b0;
                    state_next = S_BEST;
                end
            end
            S_BEST:
            begin
                ap_raddr = cl_ap_reg;
                ph_next  = 1'b1;
                if (ph_reg)
                begin
                    if (!ap_rd.best_valid || ctx_reg > ap_rd.best_count)
                    begin
                        ap_we                = 1'b1;
                        ap_waddr             = cl_ap_reg;
                        ap_wdata.addr        = ap_rd.addr;
                        ap_wdata.best_valid  = 1'b1;
                        ap_wdata.best_client = fidx_reg[CW-1:0];
                        ap_wdata.best_count  = ctx_reg;
                    end
                    status_next = dropped_reg ? ST_FULL : ST_COUNTED;
                    state_next  = S_DONE;
                end
            end
            S_PRSCAN:
            begin
                if (pv_reg && pr_rd.src == cmd_reg.key_a && pr_rd.dst == cmd_reg.key_b)
                begin
                    fidx_next  = pidx_reg;
                    fnew_next  = 1'b0;
                    crx_next   = pr_rd.cnt;
                    state_next = S_PRUPD;
                end
                else if (!pv_reg && !scan_issue)
                begin
                    if (pr_cnt_reg < PCW'(PAIR_ENTRIES))
                    begin
                        fidx_next  = SW'(pr_cnt_reg);
                        fnew_next  = 1'b1;
                        crx_next   = '0;
                        state_next = S_PRUPD;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                end
            end
            S_PRUPD:
            begin
                pr_we        = 1'b1;
                pr_waddr     = fidx_reg[PW-1:0];
                pr_wdata.src = cmd_reg.key_a;
                pr_wdata.dst = cmd_reg.key_b;
                pr_wdata.cnt = sat_inc(crx_reg);
                if (fnew_reg)
                begin
                    pr_cnt_next = pr_cnt_reg + 1'b1;
                end
                status_next = dropped_reg ? ST_FULL : ST_COUNTED;
                state_next  = S_DONE;
            end
            S_QBEST:
            begin
                ap_raddr = txi_reg;
                ph_next  = 1'b1;
                if (ph_reg)
                begin
                    cl_raddr = ap_rd.best_client;
                    if (!ap_rd.best_valid)
                    begin
                        status_next = ST_NONE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_QCL;
                    end
                end
            end
            S_QCL:
            begin
                status_next  = ST_FOUND;
                partner_next = cl_rd.addr;
                state_next   = S_DONE;
            end
            S_QSCAN:
            begin
                if (pv_reg && cl_rd.addr == cmd_reg.key_a)
                begin
                    ap_raddr = cl_rd.ap;
                    qv_next  = 1'b1;
                    qrx_next = cl_rd.rx;
                end
                if (qv_reg)
                begin
                    if (!have_reg || qrx_reg > brx_reg ||
                        (qrx_reg == brx_reg && ap_rd.addr < bap_reg))
                    begin
                        have_next = 1'b1;
                        brx_next  = qrx_reg;
                        bap_next  = ap_rd.addr;
                    end
                end
                if (!scan_issue && !pv_reg && !qv_reg)
                begin
                    status_next  = have_reg ? ST_FOUND : ST_NONE;
                    partner_next = have_reg ? bap_reg : '0;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_next.status  = status_reg;
                    out_next.partner = partner_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ap_cnt_reg    <= '0;
            cl_cnt_reg    <= '0;
            pr_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
            qv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ap_cnt_reg    <= ap_cnt_next;
            cl_cnt_reg    <= cl_cnt_next;
            pr_cnt_reg    <= pr_cnt_next;
            out_valid_reg <= out_valid_next;
            pv_reg        <= pv_next;
            qv_reg        <= qv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        si_reg      <= si_next;
        pidx_reg    <= pidx_next;
        fidx_reg    <= fidx_next;
        txh_reg     <= txh_next;
        rxh_reg     <= rxh_next;
        txi_reg     <= txi_next;
        rxi_reg     <= rxi_next;
        dropped_reg <= dropped_next;
        ph_reg      <= ph_next;
        cl_ap_reg   <= cl_ap_next;
        cl_addr_reg <= cl_addr_next;
        rxmode_reg  <= rxmode_next;
        fnew_reg    <= fnew_next;
        crx_reg     <= crx_next;
        ctx_reg     <= ctx_next;
        qrx_reg     <= qrx_next;
        brx_reg     <= brx_next;
        have_reg    <= have_next;
        bap_reg     <= bap_next;
        status_reg  <= status_next;
        partner_reg <= partner_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (ap_we)
        begin
            ap_mem[ap_waddr] <= ap_wdata;
        end
        ap_rd <= ap_mem[ap_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cl_we)
        begin
            cl_mem[cl_waddr] <= cl_wdata;
        end
        cl_rd <= cl_mem[cl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pr_we)
        begin
            pr_mem[pr_waddr] <= pr_wdata;
        end
        pr_rd <= pr_mem[pr_raddr];
    end

    `WSTT_ASSERT_HOLDS(a_ap_fill, clk, rst_n, 1'b1, ap_cnt_reg <= ACW'(AP_ENTRIES))
    `WSTT_ASSERT_HOLDS(a_cl_fill, clk, rst_n, 1'b1, cl_cnt_reg <= CCW'(CLIENT_ENTRIES))
    `WSTT_ASSERT_HOLDS(a_partner, clk, rst_n, out_valid_reg && out_reg.partner != '0, out_reg.status == ST_FOUND)
    `WSTT_ASSERT_NEXT(a_pop_scan, clk, rst_n, cmd_pop, state_reg == S_APSCAN)

endmodule

@@ hw/rtl/wifi_station_traffic_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wi-Fi station traffic table
// Counts frames per access point client or address pair and answers queries.
//
//   Channel   Direction  Beat type  Handshake
//   item      in         item_t     item_valid / item_stall
//   result    out        result_t   result_valid / result_stall
//
// Each beat gives exactly one result. The single read port of each table is
// swept one entry a cycle over the filled access point, client and pair
// entries. A frame or query result is only issued once the previous result
// is no longer held off.
// A two-entry queue decouples intake. Reset empties all tables at once through
// their fill counts.
// A stalled result holds; the next item may still be accepted meanwhile.
// ----------------------------------------------------------------------------
module wifi_station_traffic_table #(
    parameter int AP_ENTRIES     = 16,
    parameter int CLIENT_ENTRIES = 64,
    parameter int PAIR_ENTRIES   = 256,
    parameter int COUNT_BITS     = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  wstt_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output wstt_pkg::result_t result
);
    import wstt_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    wstt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    wstt_back #(
        .AP_ENTRIES     (AP_ENTRIES),
        .CLIENT_ENTRIES (CLIENT_ENTRIES),
        .PAIR_ENTRIES   (PAIR_ENTRIES),
        .COUNT_BITS     (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ verif/wifi_station_traffic_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Station traffic table checker
// Watches both channels. Each accepted input beat is run through a local
// model of the access point, client and pair tables. The model's result is
// queued, and every result beat is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module wifi_station_traffic_table_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  wstt_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  wstt_pkg::result_t result,
    output int                errors,
    output int                pending
);
    import wstt_pkg::*;

    localparam int NUM_APS     = 16;
    localparam int NUM_CLIENTS = 64;
    localparam int NUM_PAIRS   = 256;
    localparam bit [31:0] COUNT_MAX = 32'hffff_ffff;

    bit        ap_used [NUM_APS];
    mac_t      ap_mac [NUM_APS];
    bit        ap_has_best [NUM_APS];
    int        ap_best [NUM_APS];
    bit [31:0] ap_best_tx [NUM_APS];

    bit        cl_used [NUM_CLIENTS];
    int        cl_ap [NUM_CLIENTS];
    mac_t      cl_mac [NUM_CLIENTS];
    bit [31:0] cl_rx [NUM_CLIENTS];
    bit [31:0] cl_tx [NUM_CLIENTS];

    bit        pr_used [NUM_PAIRS];
    mac_t      pr_src [NUM_PAIRS];
    mac_t      pr_dst [NUM_PAIRS];
    bit [31:0] pr_cnt [NUM_PAIRS];

    result_t   awaited_results[$];

    assign pending = awaited_results.size();

    function automatic bit [31:0] bump(bit [31:0] v);
        return (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

    function automatic int ap_lookup(mac_t m);
        for (int i = 0; i < NUM_APS; i++)
            if (ap_used[i] && ap_mac[i] == m)
                return i;
        return -1;
    endfunction

    function automatic int client_entry(int ap, mac_t m);
        int slot;
        slot = -1;
        for (int i = 0; i < NUM_CLIENTS; i++)
        begin
            if (cl_used[i])
            begin
                if (cl_ap[i] == ap && cl_mac[i] == m)
                    return i;
            end
            else if (slot < 0)
                slot = i;
        end
        if (slot >= 0)
        begin
            cl_used[slot] = 1'b1;
            cl_ap[slot]   = ap;
            cl_mac[slot]  = m;
            cl_rx[slot]   = '0;
            cl_tx[slot]   = '0;
        end
        return slot;
    endfunction

    function automatic int pair_entry(mac_t s, mac_t d);
        int slot;
        slot = -1;
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            if (pr_used[i])
            begin
                if (pr_src[i] == s && pr_dst[i] == d)
                    return i;
            end
            else if (slot < 0)
                slot = i;
        end
        if (slot >= 0)
        begin
            pr_used[slot] = 1'b1;
            pr_src[slot]  = s;
            pr_dst[slot]  = d;
            pr_cnt[slot]  = '0;
        end
        return slot;
    endfunction

    function automatic status_t count_frame(item_t it);
        bit dropped;
        int ap;
        int c;
        int p;
        int slot;
        dropped = 1'b0;
        slot = -1;
        if (it.is_beacon && it.has_transmitter && ap_lookup(it.transmitter) < 0)
        begin
            for (int i = NUM_APS - 1; i >= 0; i--)
                if (!ap_used[i])
                    slot = i;
            if (slot < 0)
                dropped = 1'b1;
            else
            begin
                ap_used[slot]     = 1'b1;
                ap_mac[slot]      = it.transmitter;
                ap_has_best[slot] = 1'b0;
            end
        end
        if (!(it.has_transmitter && it.has_receiver))
            return dropped ? ST_FULL : ST_MISSING;
        ap = ap_lookup(it.transmitter);
        if (ap >= 0 && it.receiver != BROADCAST_MAC)
        begin
            c = client_entry(ap, it.receiver);
            if (c < 0)
                return ST_FULL;
            cl_rx[c] = bump(cl_rx[c]);
            return dropped ? ST_FULL : ST_COUNTED;
        end
        ap = ap_lookup(it.receiver);
        if (ap >= 0 && it.transmitter != BROADCAST_MAC)
        begin
            c = client_entry(ap, it.transmitter);
            if (c < 0)
                return ST_FULL;
            cl_tx[c] = bump(cl_tx[c]);
            if (!ap_has_best[ap] || cl_tx[c] > ap_best_tx[ap])
            begin
                ap_has_best[ap] = 1'b1;
                ap_best[ap]     = c;
                ap_best_tx[ap]  = cl_tx[c];
            end
            return dropped ? ST_FULL : ST_COUNTED;
        end
        p = pair_entry(it.transmitter, it.receiver);
        if (p < 0)
            return ST_FULL;
        pr_cnt[p] = bump(pr_cnt[p]);
        return dropped ? ST_FULL : ST_COUNTED;
    endfunction

    function automatic result_t busiest_partner(mac_t m);
        result_t   r;
        int        ap;
        bit        have;
        mac_t      best_mac;
        bit [31:0] best_rx;
        r = '{status: ST_NONE, partner: '0};
        have = 1'b0;
        best_mac = '0;
        best_rx = '0;
        ap = ap_lookup(m);
        if (ap >= 0)
        begin
            if (ap_has_best[ap])
                r = '{status: ST_FOUND, partner: cl_mac[ap_best[ap]]};
            return r;
        end
        for (int i = 0; i < NUM_CLIENTS; i++)
        begin
            if (!cl_used[i] || cl_mac[i] != m || !ap_used[cl_ap[i]])
                continue;
            if (!have || cl_rx[i] > best_rx
                    || (cl_rx[i] == best_rx && ap_mac[cl_ap[i]] < best_mac))
            begin
                have     = 1'b1;
                best_mac = ap_mac[cl_ap[i]];
                best_rx  = cl_rx[i];
            end
        end
        if (have)
            r = '{status: ST_FOUND, partner: best_mac};
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_APS; i++)
            begin
                ap_used[i]     = 1'b0;
                ap_has_best[i] = 1'b0;
            end
            for (int i = 0; i < NUM_CLIENTS; i++)
                cl_used[i] = 1'b0;
            for (int i = 0; i < NUM_PAIRS; i++)
                pr_used[i] = 1'b0;
            awaited_results.delete();
            errors = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, got status %0d partner %h",
                             $realtime, result.status, result.partner);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $realtime, want.status, result.status);
                        errors++;
                    end
                    if (result.partner !== want.partner)
                    begin
                        $display("%0t: partner expected %h, got %h",
                                 $realtime, want.partner, result.partner);
                        errors++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                if (item.kind)
                    awaited_results.push_back(busiest_partner(item.station));
                else
                    awaited_results.push_back(result_t'{status: count_frame(item),
                                                        partner: '0});
            end
        end
    end

endmodule

@@ verif/wifi_station_traffic_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Station traffic table testbench
// Drives directed frames and queries covering beacons, broadcast, missing
// addresses and ties, then random traffic drawn from small address pools so
// that all three tables fill up. Both sides idle at random and the result
// side holds off once for a long stretch. The checker gives the verdict data.
// ----------------------------------------------------------------------------
module wifi_station_traffic_table_tb;
    import wstt_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    int      errors;
    int      pending;
    int      beats_sent;

    mac_t    ap_pool [20];
    mac_t    sta_pool [48];

    wifi_station_traffic_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    wifi_station_traffic_table_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60ms;
        $display("wifi_station_traffic_table: mismatch");
        $finish;
    end

    function automatic mac_t any_mac();
        return mac_t'({$urandom, $urandom});
    endfunction

    function automatic item_t make_beat(logic k, logic b, logic ht, logic hr,
                                        mac_t tx, mac_t rx, mac_t st);
        item_t it;
        it.kind = k;
        it.is_beacon = b;
        it.has_transmitter = ht;
        it.has_receiver = hr;
        it.transmitter = tx;
        it.receiver = rx;
        it.station = st;
        return it;
    endfunction

    function automatic mac_t pick_mac();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return ap_pool[$urandom_range(0, 19)];
        if (r < 8)
            return sta_pool[$urandom_range(0, 47)];
        if (r == 8)
            return BROADCAST_MAC;
        return any_mac();
    endfunction

    function automatic item_t random_beat();
        item_t it;
        it = make_beat(1'b0, $urandom_range(0, 9) == 0, $urandom_range(0, 19) != 0,
                       $urandom_range(0, 19) != 0, pick_mac(), pick_mac(), any_mac());
        if (it.is_beacon && $urandom_range(0, 4) != 0)
            it.transmitter = ap_pool[$urandom_range(0, 19)];
        if ($urandom_range(0, 4) == 0)
        begin
            it.kind = 1'b1;
            it.station = pick_mac();
        end
        return it;
    endfunction

    task automatic send(item_t it);
        if (!(beats_sent >= 600 && beats_sent < 900))
            while ($urandom_range(0, 99) < 10)
            begin
                item_valid = 1'b0;
                @(negedge clk);
            end
        item = it;
        item_valid = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    initial
    begin
        bit held;
        held = 1'b0;
        result_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && beats_sent >= 300)
            begin
                held = 1'b1;
                result_stall = 1'b1;
                repeat (2000)
                    @(negedge clk);
            end
            else if (beats_sent >= 1000 && beats_sent < 1300)
                result_stall = 1'b0;
            else
                result_stall = $urandom_range(0, 99) < 10;
        end
    end

    initial
    begin
        mac_t a0;
        mac_t a1;
        mac_t s0;
        mac_t s1;
        int   guard;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        beats_sent = 0;
        for (int i = 0; i < 20; i++)
            ap_pool[i] = any_mac();
        for (int i = 0; i < 48; i++)
            sta_pool[i] = any_mac();
        a0 = ap_pool[0];
        a1 = ap_pool[1];
        s0 = sta_pool[0];
        s1 = sta_pool[1];
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(make_beat(1'b1, 1'b0, 1'b0, 1'b0, '0, '0, s0));
        send(make_beat(1'b0, 1'b1, 1'b0, 1'b1, a0, s0, '0));
        send(make_beat(1'b0, 1'b1, 1'b1, 1'b0, a0, s0, '0));
        send(make_beat(1'b0, 1'b1, 1'b1, 1'b1, a0, s0, '0));
        send(make_beat(1'b1, 1'b0, 1'b0, 1'b0, '0, '0, a0));
        send(make_beat(1'b0, 1'b0, 1'b1, 1'b1, s0, a0, '0));
        send(make_beat(1'b1, 1'b0, 1'b0, 1'b0, '0, '0, a0));
        send(make_beat(1'b1, 1'b0, 1'b0, 1'b0, '0, '0, s0));
        send(make_beat(1'b0, 1'b1, 1'b1, 1'b0, BROADCAST_MAC, '0, '0));
        send(make_beat(1'b0, 1'b0, 1'b1, 1'b1, BROADCAST_MAC, s1, '0));
        send(make_beat(1'b0, 1'b0, 1'b1, 1'b1, a0, BROADCAST_MAC, '0));
        send(make_beat(1'b0, 1'b0, 1'b1, 1'b1, s1, s0, '0));
        send(make_beat(1'b0, 1'b0, 1'b1, 1'b1, '0, '0, '0));
        send(make_beat(1'b0, 1'b0, 1'b1, 1'b0, s0, s1, '0));
        send(make_beat(1'b0, 1'b1, 1'b1, 1'b1, a1, s0, '0));
        send(make_beat(1'b1, 1'b0, 1'b0, 1'b0, '0, '0, s0));
        send(make_beat(1'b1, 1'b1, 1'b1, 1'b1, BROADCAST_MAC, BROADCAST_MAC,
                       BROADCAST_MAC));
        send(make_beat(1'b1, 1'b0, 1'b0, 1'b0, '0, '0, BROADCAST_MAC));
        send(make_beat(1'b1, 1'b0, 1'b0, 1'b0, '0, '0, s1));

        for (int n = 0; n < 1800; n++)
            send(random_beat());
        item_valid = 1'b0;

        guard = 0;
        while (pending != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (500)
            @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("wifi_station_traffic_table: match");
        else
            $display("wifi_station_traffic_table: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/wstt_pkg.sv
hw/rtl/wstt_front.sv
hw/rtl/wstt_back.sv
hw/rtl/wifi_station_traffic_table.sv
verif/wifi_station_traffic_table_checker.sv
verif/wifi_station_traffic_table_tb.sv
